### hdl/assert_macros.svh
// Assertion macros shared by the execute unit RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define SEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/seu_pkg.sv
// Package for the scalar execute unit: class, opcode, status and control register codes, and register decode.
// No dependencies.
`default_nettype none
package seu_pkg;
    localparam logic [3:0] CLS_MEM  = 4'd0;
    localparam logic [3:0] CLS_CTRL = 4'd2;
    localparam logic [3:0] CLS_MATH = 4'd3;

    localparam logic [7:0] M_LOAD = 8'h10, M_STORE = 8'h11, M_MOVE = 8'h12,
        M_RLOAD = 8'h13, M_RSTORE = 8'h14, M_PUSH = 8'h15, M_POP = 8'h16,
        M_LOADC = 8'h17, M_CLEAR = 8'h18, M_LOADB = 8'h19, M_STOREB = 8'h1a,
        M_RLOADB = 8'h1b, M_RSTOREB = 8'h1c;
    localparam logic [7:0] C_JMP = 8'h10, C_RJMP = 8'h11, C_JMPR = 8'h12,
        C_RJMPR = 8'h13, C_CLRF = 8'h14, C_CJMP = 8'h15, C_CRJMP = 8'h16,
        C_CJMPR = 8'h17, C_CRJMPR = 8'h18, C_SETSYS = 8'h19, C_SYSCALL = 8'h1a,
        C_CALL = 8'h1b, C_RCALL = 8'h1c, C_RET = 8'h1d, C_HALT = 8'h1f;
    localparam logic [7:0] A_EQ = 8'h10, A_GT = 8'h11, A_LT = 8'h12, A_ADD = 8'h13,
        A_SUB = 8'h14, A_MUL = 8'h15, A_DIV = 8'h16, A_MOD = 8'h17, A_NAND = 8'h18;

    localparam logic [1:0] ST_OK = 2'd0, ST_BADREG = 2'd1, ST_UNSUP = 2'd2;

    localparam logic [2:0] CR_OP = 3'd0, CR_PC = 3'd1, CR_SP = 3'd2,
        CR_FL = 3'd3, CR_SY = 3'd4;

    // Decoded register number: valid bit plus 5-bit file index (16+ is control)
    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_reg_sel;

    function automatic t_reg_sel reg_decode(input logic [31:0] n);
        t_reg_sel r;
        r.ok = 1'b0;
        r.idx = 5'd0;
        if (n[31:4] == 28'h1) begin
            r.ok = 1'b1;
            r.idx = {1'b0, n[3:0]};
        end else if (n[31:3] == 29'h6) begin
            r.ok = 1'b1;
            r.idx = {2'b10, n[2:0]};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### hdl/scalar_execute_unit.sv
// Scalar execute unit: one decoded instruction per request, one result each.
// Channels: input request (i_valid/o_stall) with instruction fields, output
// request (o_valid/i_stall) with next_pc, flag, destination, halt and status.
// After reset a clearing pass writes MEM_BYTES zero bytes, one per cycle,
// while o_stall is high.
// Word loads, stores, push, pop, call, syscall and return move four bytes
// over the byte-wide memory port with its registered read, byte loads and
// stores one; add/sub/nand/compare run bit serial, mul takes 32 shift-add
// steps and div/mod 32 restoring steps (skipped on divide by zero).
// One item is in flight at a time; the next request is taken at the earliest
// on the edge that takes the previous result.
// While the receiver stalls the result register holds and the input stalls.
// Reset is synchronous, active low, and clears registers, flag and halt mark.
// Once halt executes, later requests are answered with halted set.
`default_nettype none
module scalar_execute_unit #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_inst_class,
    input  wire logic [7:0]  i_opcode,
    input  wire logic [31:0] i_arg_first,
    input  wire logic [31:0] i_arg_second,
    input  wire logic [7:0]  i_arg_third,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_next_pc,
    output logic [31:0]      o_flag_value,
    output logic [31:0]      o_dest_value,
    output logic             o_dest_written,
    output logic             o_halted,
    output logic [1:0]       o_status
);
    import seu_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RD, S_WR, S_ALU, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [AW:0]  r_clr;
    logic [3:0]   r_cls;
    logic [7:0]   r_op;
    logic [31:0]  r_a1, r_a2;
    logic [7:0]   r_a3;
    logic [31:0]  r_regs [24];
    logic         r_halt;
    // datapath
    logic [31:0]  r_addr, r_acc, r_x, r_y;
    logic [31:0]  r_rem;
    logic [5:0]   r_cnt;
    logic [2:0]   r_nb;
    logic         r_carry;
    logic         r_dw;
    logic [4:0]   r_dst;
    logic [31:0]  r_val;
    logic [1:0]   r_st;
    logic         r_fin_pc, r_fin_sp;
    logic [31:0]  r_pc_new;
    logic [1:0]   r_sp_mode;
    // memory
    logic [7:0]   r_mem [MEM_BYTES];
    logic [7:0]   r_rdata;
    logic         r_mwe;
    logic [AW-1:0] r_maddr;
    logic [7:0]   r_mwdata;

    t_reg_sel ra, rb, rc;
    logic [31:0] x_a, x_b, x_c, opb;
    assign ra = reg_decode(r_a1);
    assign rb = reg_decode(r_a2);
    assign rc = reg_decode({24'd0, r_a3});
    assign x_a = r_regs[ra.idx];
    assign x_b = r_regs[rb.idx];
    assign x_c = r_regs[rc.idx];
    assign opb = r_regs[{2'b10, CR_OP}];

    // take a new request only when idle and the result register frees up
    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);

    // byte-wide memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_mwe) r_mem[r_maddr] <= r_mwdata;
        r_rdata <= r_mem[r_maddr];
    end

    logic sum_bit, sum_c;
    always_comb begin
        sum_bit = 1'b0;
        sum_c = 1'b0;
        // one bit of add (y+z) or subtract (y+~z+1) per cycle
        if (r_op == A_ADD) {sum_c, sum_bit} = {1'b0, r_x[0]} + {1'b0, r_y[0]} + {1'b0, r_carry};
        else {sum_c, sum_bit} = {1'b0, r_x[0]} + {1'b0, ~r_y[0]} + {1'b0, r_carry};
    end

    logic [32:0] div_try;
    assign div_try = {r_rem[31:0], r_x[31]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_halt <= 1'b0;
            r_mwe <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < 24; i++) r_regs[i] <= '0;
        end else begin
            r_mwe <= 1'b0;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                // clear memory one byte per cycle
                S_CLR: begin
                    r_mwe <= 1'b1;
                    r_maddr <= r_clr[AW-1:0];
                    r_mwdata <= 8'd0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(MEM_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_cls <= i_inst_class;
                        r_op <= i_opcode;
                        r_a1 <= i_arg_first;
                        r_a2 <= i_arg_second;
                        r_a3 <= i_arg_third;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    logic ok;
                    logic [1:0] need;
                    ok = 1'b0;
                    need = 2'd0;
                    r_dw <= 1'b0;
                    r_val <= '0;
                    r_fin_pc <= 1'b0;
                    r_fin_sp <= 1'b0;
                    r_sp_mode <= 2'd0;
                    r_nb <= 3'd0;
                    r_cnt <= '0;
                    r_carry <= 1'b0;
                    case (r_cls)
                        CLS_MEM: begin
                            ok = (r_op >= 8'h10 && r_op <= 8'h1c);
                            need = (r_op == M_MOVE || r_op == M_RLOAD || r_op == M_RSTORE
                                || r_op == M_RLOADB || r_op == M_RSTOREB) ? 2'd2 : 2'd1;
                        end
                        CLS_CTRL: begin
                            ok = (r_op >= 8'h10 && r_op <= 8'h1d) || r_op == C_HALT;
                            need = (r_op == C_JMPR || r_op == C_RJMPR || r_op == C_CJMPR
                                || r_op == C_CRJMPR) ? 2'd1 : 2'd0;
                        end
                        CLS_MATH: begin
                            ok = (r_op >= 8'h10 && r_op <= 8'h18);
                            need = (r_op <= 8'h12) ? 2'd2 : 2'd3;
                        end
                        default: ok = 1'b0;
                    endcase
                    r_st <= ST_OK;
                    r_state <= S_FIN;
                    if (r_halt) begin
                        r_st <= ST_OK;
                    end else if (!ok) begin
                        r_st <= ST_UNSUP;
                    end else if ((need >= 2'd1 && !ra.ok) || (need >= 2'd2 && !rb.ok)
                            || (need == 2'd3 && !rc.ok)) begin
                        r_st <= ST_BADREG;
                    end else begin
                        r_dst <= ra.idx;
                        case (r_cls)
                            CLS_MEM: begin
                                case (r_op)
                                    M_LOAD: begin
                                        r_addr <= r_a2; r_nb <= 3'd4; r_state <= S_RD;
                                    end
                                    M_RLOAD: begin
                                        r_addr <= x_b; r_nb <= 3'd4; r_state <= S_RD;
                                    end
                                    M_LOADB: begin
                                        r_addr <= r_a2; r_nb <= 3'd1; r_state <= S_RD;
                                    end
                                    M_RLOADB: begin
                                        r_addr <= x_b; r_nb <= 3'd1; r_state <= S_RD;
                                    end
                                    M_POP: begin
                                        r_addr <= r_regs[{2'b10, CR_SP}] - 32'd4;
                                        r_regs[{2'b10, CR_SP}] <= r_regs[{2'b10, CR_SP}] - 32'd4;
                                        r_nb <= 3'd4; r_state <= S_RD;
                                    end
                                    M_STORE: begin
                                        r_addr <= r_a2; r_acc <= x_a; r_nb <= 3'd4;
                                        r_state <= S_WR;
                                    end
                                    M_RSTORE: begin
                                        r_addr <= x_b; r_acc <= x_a; r_nb <= 3'd4;
                                        r_state <= S_WR;
                                    end
                                    M_STOREB: begin
                                        r_addr <= r_a2; r_acc <= {x_a[7:0], 24'd0};
                                        r_nb <= 3'd1; r_state <= S_WR;
                                    end
                                    M_RSTOREB: begin
                                        r_addr <= x_b; r_acc <= {x_a[7:0], 24'd0};
                                        r_nb <= 3'd1; r_state <= S_WR;
                                    end
                                    M_PUSH: begin
                                        r_addr <= r_regs[{2'b10, CR_SP}]; r_acc <= x_a;
                                        r_nb <= 3'd4; r_fin_sp <= 1'b1; r_state <= S_WR;
                                    end
                                    M_MOVE: begin
                                        r_dst <= rb.idx; r_dw <= 1'b1; r_val <= x_a;
                                    end
                                    M_LOADC: begin
                                        r_dw <= 1'b1; r_val <= r_a2;
                                    end
                                    default: begin
                                        r_dw <= 1'b1; r_val <= '0;
                                    end
                                endcase
                            end
                            CLS_CTRL: begin
                                case (r_op)
                                    C_JMP: r_regs[{2'b10, CR_PC}] <= r_a1;
                                    C_RJMP: r_regs[{2'b10, CR_PC}] <= opb + r_a1;
                                    C_JMPR: r_regs[{2'b10, CR_PC}] <= x_a;
                                    C_RJMPR: r_regs[{2'b10, CR_PC}] <= opb + x_a;
                                    C_CLRF: r_regs[{2'b10, CR_FL}] <= '0;
                                    C_CJMP, C_CRJMP, C_CJMPR, C_CRJMPR: begin
                                        if (r_regs[{2'b10, CR_FL}] != 32'd0) begin
                                            r_regs[{2'b10, CR_FL}] <= '0;
                                            case (r_op)
                                                C_CJMP: r_regs[{2'b10, CR_PC}] <= r_a1;
                                                C_CRJMP: r_regs[{2'b10, CR_PC}] <= r_a1 + opb;
                                                C_CJMPR: r_regs[{2'b10, CR_PC}] <= x_a;
                                                default: r_regs[{2'b10, CR_PC}] <= x_a + opb;
                                            endcase
                                        end
                                    end
                                    C_SETSYS: r_regs[{2'b10, CR_SY}] <= r_a1;
                                    C_SYSCALL, C_CALL, C_RCALL: begin
                                        r_addr <= r_regs[{2'b10, CR_SP}];
                                        r_acc <= r_regs[{2'b10, CR_PC}];
                                        r_nb <= 3'd4;
                                        r_fin_sp <= 1'b1;
                                        r_fin_pc <= 1'b1;
                                        r_pc_new <= (r_op == C_SYSCALL) ? r_regs[{2'b10, CR_SY}]
                                            : (r_op == C_CALL) ? r_a1 : r_a1 + opb;
                                        r_state <= S_WR;
                                    end
                                    C_RET: begin
                                        r_addr <= r_regs[{2'b10, CR_SP}] - 32'd4;
                                        r_regs[{2'b10, CR_SP}] <= r_regs[{2'b10, CR_SP}] - 32'd4;
                                        r_nb <= 3'd4; r_sp_mode <= 2'd1; r_state <= S_RD;
                                    end
                                    default: r_halt <= 1'b1;
                                endcase
                            end
                            default: begin
                                r_x <= x_b;
                                r_y <= x_c;
                                r_acc <= '0;
                                r_carry <= (r_op == A_SUB);
                                r_rem <= '0;
                                case (r_op)
                                    A_EQ, A_GT, A_LT: begin
                                        // compare x_a with x_b by serial subtract
                                        r_x <= x_a; r_y <= x_b; r_carry <= 1'b1;
                                        r_state <= S_ALU;
                                    end
                                    A_MUL: r_state <= S_MUL;
                                    A_DIV, A_MOD: begin
                                        if (x_c == 32'd0) r_regs[{2'b10, CR_FL}] <= 32'd1;
                                        else r_state <= S_DIV;
                                    end
                                    default: r_state <= S_ALU;
                                endcase
                            end
                        endcase
                    end
                end
                // read bytes, big-endian, one per cycle, through the registered memory read
                S_RD: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_maddr <= r_addr[AW-1:0];
                    r_addr <= r_addr + 32'd1;
                    if (r_cnt >= 6'd2)
                        r_acc <= {r_acc[23:0], r_rdata};
                    if (r_cnt == 6'd0) r_acc <= '0;
                    if (r_cnt == {3'd0, r_nb} + 6'd1) begin
                        r_state <= S_FIN;
                        if (r_sp_mode == 2'd1) begin
                            r_regs[{2'b10, CR_PC}] <= {r_acc[23:0], r_rdata};
                        end else begin
                            r_dw <= 1'b1;
                            r_val <= {r_acc[23:0], r_rdata};
                        end
                    end
                end
                // write bytes, most significant first
                S_WR: begin
                    r_mwe <= 1'b1;
                    r_maddr <= r_addr[AW-1:0];
                    r_mwdata <= r_acc[31:24];
                    r_acc <= {r_acc[23:0], 8'd0};
                    r_addr <= r_addr + 32'd1;
                    r_nb <= r_nb - 1'b1;
                    if (r_nb == 3'd1) begin
                        r_state <= S_FIN;
                        if (r_fin_sp)
                            r_regs[{2'b10, CR_SP}] <= r_regs[{2'b10, CR_SP}] + 32'd4;
                        if (r_fin_pc) r_regs[{2'b10, CR_PC}] <= r_pc_new;
                    end
                end
                // bit-serial add, subtract, nand and compare
                S_ALU: begin
                    logic rb_bit;
                    rb_bit = (r_op == A_NAND) ? ~(r_x[0] & r_y[0]) : sum_bit;
                    if (r_op <= A_LT) rb_bit = r_x[0] ^ r_y[0];
                    r_acc <= {rb_bit, r_acc[31:1]};
                    r_carry <= sum_c;
                    if (r_op <= A_LT && (r_x[0] ^ r_y[0])) r_rem[0] <= 1'b1;
                    r_x <= {1'b0, r_x[31:1]};
                    r_y <= {1'b0, r_y[31:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        logic ne, cy, fin_c;
                        ne = r_rem[0] | (r_x[0] ^ r_y[0]);
                        fin_c = ({1'b0, r_x[0]} + {1'b0, ~r_y[0]} + {1'b0, r_carry}) > 2'd1;
                        cy = fin_c; // carry out set when x >= y
                        r_state <= S_FIN;
                        case (r_op)
                            A_EQ: r_regs[{2'b10, CR_FL}] <= {31'd0, ~ne};
                            A_GT: r_regs[{2'b10, CR_FL}] <= {31'd0, cy & ne};
                            A_LT: r_regs[{2'b10, CR_FL}] <= {31'd0, ~cy};
                            default: begin
                                r_dw <= 1'b1;
                                r_val <= {rb_bit, r_acc[31:1]};
                            end
                        endcase
                    end
                end
                // shift-add multiply, low 32 bits
                S_MUL: begin
                    logic [31:0] nacc;
                    nacc = r_y[0] ? r_acc + r_x : r_acc;
                    r_acc <= nacc;
                    r_x <= {r_x[30:0], 1'b0};
                    r_y <= {1'b0, r_y[31:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_dw <= 1'b1; r_val <= nacc; r_state <= S_FIN;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    logic [31:0] nrem;
                    logic qb;
                    qb = !div_try[32];
                    nrem = qb ? div_try[31:0] : {r_rem[30:0], r_x[31]};
                    r_rem <= nrem;
                    r_x <= {r_x[30:0], qb};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_dw <= 1'b1;
                        r_val <= (r_op == A_DIV) ? {r_x[30:0], qb} : nrem;
                        r_state <= S_FIN;
                    end
                end
                // commit destination register
                S_FIN: begin
                    if (r_dw) r_regs[r_dst] <= r_val;
                    r_state <= S_OUT;
                end
                default: begin
                    o_valid <= 1'b1;
                    o_next_pc <= r_regs[{2'b10, CR_PC}];
                    o_flag_value <= r_regs[{2'b10, CR_FL}];
                    o_dest_value <= r_dw ? r_val : 32'd0;
                    o_dest_written <= r_dw;
                    o_halted <= r_halt;
                    o_status <= r_st;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SEU_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "busy not stalled")
    `SEU_ASSERT_IMP(a_halt_quiet, i_clk, i_rst_n, o_valid && o_halted, !o_dest_written, "write after halt")
    `SEU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
    `SEU_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status != 2'd3, "bad status code")
endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for scalar_execute_unit: random and directed instruction requests,
// each result checked against an in-bench model of registers, memory and halt.
// Depends on seu_pkg and the scalar_execute_unit RTL.
`default_nettype none
module tb;
    import seu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEMB = 4096;
    localparam int MAX_CYCLES = 2000000;

    typedef struct packed {
        logic [3:0]  cls;
        logic [7:0]  op;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [7:0]  a3;
    } t_inst;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] fl;
        logic [31:0] dv;
        logic        dw;
        logic        hl;
        logic [1:0]  st;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_inst_class = '0;
    logic [7:0]  i_opcode = '0;
    logic [31:0] i_arg_first = '0;
    logic [31:0] i_arg_second = '0;
    logic [7:0]  i_arg_third = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_next_pc, o_flag_value, o_dest_value;
    logic        o_dest_written, o_halted;
    logic [1:0]  o_status;

    scalar_execute_unit #(.MEM_BYTES(MEMB)) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state
    logic [31:0] sregs [16];
    logic [31:0] cregs [8];
    logic [7:0]  dmem [MEMB];
    logic        halt_seen;

    t_inst    pending_insts[$];
    t_outcome expected_results[$];
    int errors = 0, mismatches = 0, results_seen = 0, cycles = 0;
    logic stim_done_r = 1'b0;
    logic drain_hold = 1'b0;

    function automatic int reg_slot(logic [31:0] n);
        if (n >= 32'h10 && n <= 32'h1f) return int'(n - 32'h10);
        if (n >= 32'h30 && n <= 32'h37) return 16 + int'(n - 32'h30);
        return -1;
    endfunction

    function automatic logic [31:0] rd_reg(int s);
        if (s < 0) return '0;
        return (s < 16) ? sregs[s] : cregs[s - 16];
    endfunction

    function automatic void wr_reg(int s, logic [31:0] v);
        if (s >= 0 && s < 16) sregs[s] = v;
        else if (s >= 16) cregs[s - 16] = v;
    endfunction

    function automatic logic [31:0] rd_word(logic [31:0] a);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) v = {v[23:0], dmem[(a + i) % MEMB]};
        return v;
    endfunction

    function automatic void wr_word(logic [31:0] a, logic [31:0] v);
        for (int i = 0; i < 4; i++) dmem[(a + i) % MEMB] = v[31 - 8 * i -: 8];
    endfunction

    function automatic void push_stack(logic [31:0] v);
        wr_word(cregs[CR_SP], v);
        cregs[CR_SP] += 4;
    endfunction

    // Execute one instruction on the model and return its outcome
    function automatic t_outcome execute_inst(t_inst t);
        t_outcome r;
        int ra, rb, rc, dst, need;
        logic ok;
        logic [1:0] st;
        logic [31:0] val, opb, adr, x, y, z;
        ra = reg_slot(t.a1);
        rb = reg_slot(t.a2);
        rc = reg_slot({24'h0, t.a3});
        dst = -1; val = '0; st = ST_OK; need = 0; ok = 1'b1;
        if (!halt_seen) begin
            if (t.cls == CLS_MEM) begin
                ok = t.op >= M_LOAD && t.op <= M_RSTOREB;
                need = (t.op == M_MOVE || t.op == M_RLOAD || t.op == M_RSTORE ||
                        t.op == M_RLOADB || t.op == M_RSTOREB) ? 2 : 1;
            end else if (t.cls == CLS_CTRL) begin
                ok = (t.op >= C_JMP && t.op <= C_RET) || t.op == C_HALT;
                need = (t.op == C_JMPR || t.op == C_RJMPR || t.op == C_CJMPR ||
                        t.op == C_CRJMPR) ? 1 : 0;
            end else if (t.cls == CLS_MATH) begin
                ok = t.op >= A_EQ && t.op <= A_NAND;
                need = (t.op <= A_LT) ? 2 : 3;
            end else begin
                ok = 1'b0;
            end
            if (!ok) st = ST_UNSUP;
            else if ((need >= 1 && ra < 0) || (need >= 2 && rb < 0) || (need >= 3 && rc < 0))
                st = ST_BADREG;
        end
        if (!halt_seen && st == ST_OK) begin
            if (t.cls == CLS_MEM) begin
                case (t.op)
                    M_LOAD:   begin dst = ra; val = rd_word(t.a2); end
                    M_STORE:  wr_word(t.a2, rd_reg(ra));
                    M_MOVE:   begin dst = rb; val = rd_reg(ra); end
                    M_RLOAD:  begin dst = ra; val = rd_word(rd_reg(rb)); end
                    M_RSTORE: wr_word(rd_reg(rb), rd_reg(ra));
                    M_PUSH:   push_stack(rd_reg(ra));
                    M_POP: begin
                        cregs[CR_SP] -= 4;
                        dst = ra; val = rd_word(cregs[CR_SP]);
                    end
                    M_LOADC:  begin dst = ra; val = t.a2; end
                    M_CLEAR:  begin dst = ra; val = '0; end
                    M_LOADB:  begin dst = ra; val = {24'h0, dmem[t.a2 % MEMB]}; end
                    M_STOREB: begin x = rd_reg(ra); dmem[t.a2 % MEMB] = x[7:0]; end
                    M_RLOADB: begin dst = ra; val = {24'h0, dmem[rd_reg(rb) % MEMB]}; end
                    default:  begin x = rd_reg(ra); dmem[rd_reg(rb) % MEMB] = x[7:0]; end
                endcase
            end else if (t.cls == CLS_CTRL) begin
                opb = cregs[CR_OP];
                case (t.op)
                    C_JMP:   cregs[CR_PC] = t.a1;
                    C_RJMP:  cregs[CR_PC] = opb + t.a1;
                    C_JMPR:  cregs[CR_PC] = rd_reg(ra);
                    C_RJMPR: cregs[CR_PC] = opb + rd_reg(ra);
                    C_CLRF:  cregs[CR_FL] = '0;
                    C_CJMP, C_CRJMP, C_CJMPR, C_CRJMPR: begin
                        if (t.op == C_CJMP) adr = t.a1;
                        else if (t.op == C_CRJMP) adr = t.a1 + opb;
                        else if (t.op == C_CJMPR) adr = rd_reg(ra);
                        else adr = rd_reg(ra) + opb;
                        if (cregs[CR_FL] != 0) begin
                            cregs[CR_FL] = '0;
                            cregs[CR_PC] = adr;
                        end
                    end
                    C_SETSYS:  cregs[CR_SY] = t.a1;
                    C_SYSCALL: begin push_stack(cregs[CR_PC]); cregs[CR_PC] = cregs[CR_SY]; end
                    C_CALL:    begin push_stack(cregs[CR_PC]); cregs[CR_PC] = t.a1; end
                    C_RCALL:   begin push_stack(cregs[CR_PC]); cregs[CR_PC] = t.a1 + opb; end
                    C_RET: begin
                        cregs[CR_SP] -= 4;
                        cregs[CR_PC] = rd_word(cregs[CR_SP]);
                    end
                    default: halt_seen = 1'b1;
                endcase
            end else begin
                x = rd_reg(ra); y = rd_reg(rb); z = rd_reg(rc);
                case (t.op)
                    A_EQ:  cregs[CR_FL] = {31'h0, x == y};
                    A_GT:  cregs[CR_FL] = {31'h0, x > y};
                    A_LT:  cregs[CR_FL] = {31'h0, x < y};
                    A_ADD: begin dst = ra; val = y + z; end
                    A_SUB: begin dst = ra; val = y - z; end
                    A_MUL: begin dst = ra; val = y * z; end
                    A_DIV, A_MOD: begin
                        if (z != 0) begin
                            dst = ra;
                            val = (t.op == A_DIV) ? y / z : y % z;
                        end else begin
                            cregs[CR_FL] = 32'd1;
                        end
                    end
                    default: begin dst = ra; val = ~(y & z); end
                endcase
            end
            if (dst >= 0) wr_reg(dst, val);
        end
        r.pc = cregs[CR_PC];
        r.fl = cregs[CR_FL];
        r.dv = (dst >= 0) ? val : '0;
        r.dw = dst >= 0;
        r.hl = halt_seen;
        r.st = st;
        return r;
    endfunction

    // Register numbers: mostly valid, sometimes bad
    function automatic logic [31:0] pick_reg();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 32'h10 + $urandom_range(0, 15);
        if (k < 90) return 32'h30 + $urandom_range(0, 7);
        if (k < 94) return 32'h20 + $urandom_range(0, 7);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_addr();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom_range(0, 63);
        if (k < 8) return $urandom();
        return MEMB - $urandom_range(1, 4);
    endfunction

    function automatic t_inst random_inst();
        t_inst t;
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) begin
            t.cls = CLS_MEM; t.op = M_LOAD + 8'($urandom_range(0, 12));
        end else if (k < 65) begin
            t.cls = CLS_CTRL; t.op = C_JMP + 8'($urandom_range(0, 13));
        end else if (k < 95) begin
            t.cls = CLS_MATH; t.op = A_EQ + 8'($urandom_range(0, 8));
        end else begin
            t.cls = 4'($urandom()); t.op = 8'($urandom());
        end
        if (t.cls == CLS_CTRL && t.op == C_HALT) t.op = C_CLRF;
        t.a1 = ($urandom_range(0, 3) == 0) ? $urandom() : pick_reg();
        if (t.cls == CLS_CTRL && $urandom_range(0, 1)) t.a1 = pick_addr();
        t.a2 = $urandom_range(0, 1) ? pick_reg() : pick_addr();
        if (t.cls == CLS_MEM && t.op == M_LOADC) t.a2 = $urandom();
        t.a3 = 8'(pick_reg());
        return t;
    endfunction

    function automatic t_inst mk(logic [3:0] c, logic [7:0] o, logic [31:0] a,
                                 logic [31:0] b, logic [7:0] d);
        t_inst t;
        t.cls = c; t.op = o; t.a1 = a; t.a2 = b; t.a3 = d;
        return t;
    endfunction

    // Fill the request queue: directed part, random part, then halt and two requests after it
    initial begin
        pending_insts.push_back(mk(CLS_MEM, M_LOADC, 32'h10, 32'hffffffff, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_LOADC, 32'h1f, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_STORE, 32'h10, 32'hfffffffe, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_LOAD, 32'h11, 32'h00000ffe, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_STOREB, 32'h10, 32'h00001005, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_LOADB, 32'h12, 32'h5, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_PUSH, 32'h10, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_POP, 32'h13, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_MEM, M_MOVE, 32'h10, 32'h33, 8'h0));
        pending_insts.push_back(mk(CLS_MATH, A_DIV, 32'h14, 32'h10, 8'h1f));
        pending_insts.push_back(mk(CLS_MATH, A_MOD, 32'h14, 32'h10, 8'h10));
        pending_insts.push_back(mk(CLS_CTRL, C_CJMP, 32'h100, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_MATH, A_MUL, 32'h15, 32'h10, 8'h10));
        pending_insts.push_back(mk(CLS_MATH, A_NAND, 32'h16, 32'h10, 8'h1f));
        pending_insts.push_back(mk(CLS_MEM, M_LOADC, 32'h31, 32'h40, 8'h0));
        pending_insts.push_back(mk(CLS_CTRL, C_CALL, 32'h200, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_CTRL, C_RET, 32'h0, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_CTRL, C_SETSYS, 32'h80, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_CTRL, C_SYSCALL, 32'h0, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_CTRL, 8'h20, 32'h0, 32'h0, 8'h0));
        pending_insts.push_back(mk(4'hf, 8'hff, 32'hffffffff, 32'hffffffff, 8'hff));
        pending_insts.push_back(mk(CLS_MEM, M_MOVE, 32'h20, 32'h10, 8'h0));
        pending_insts.push_back(mk(CLS_MATH, A_ADD, 32'h10, 32'h11, 8'hff));
        for (int i = 0; i < 1100; i++) pending_insts.push_back(random_inst());
        pending_insts.push_back(mk(CLS_CTRL, C_HALT, 32'h0, 32'h0, 8'h0));
        pending_insts.push_back(mk(CLS_MATH, A_ADD, 32'h10, 32'h11, 8'h12));
        pending_insts.push_back(mk(CLS_MEM, M_LOADC, 32'h10, 32'h1, 8'h0));
    end

    // Model reset and release of the block's reset
    initial begin
        for (int i = 0; i < 16; i++) sregs[i] = '0;
        for (int i = 0; i < 8; i++) cregs[i] = '0;
        for (int i = 0; i < MEMB; i++) dmem[i] = '0;
        halt_seen = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    int sent = 0;
    int gap_left = 0;

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: present requests, hold while stalled, insert random gaps, drain after the 600th request
    always @(posedge i_clk) begin
        t_inst t;
        logic done_now;
        done_now = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(execute_inst(pending_insts.pop_front()));
                sent++;
                done_now = 1'b1;
                if (sent == 600) drain_hold <= 1'b1;
            end
            if (i_valid && !done_now) begin
                // hold the stalled request
            end else if (drain_hold && (expected_results.size() != 0 || done_now)) begin
                i_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
                if (drain_hold) drain_hold <= 1'b0;
            end else if (pending_insts.size() > 0) begin
                if (drain_hold) drain_hold <= 1'b0;
                t = pending_insts[0];
                if (done_now && ($urandom_range(0, 1) || pending_insts.size() == 0)) begin
                    i_valid <= 1'b0;
                    gap_left <= rand_gap();
                end else begin
                    i_valid <= 1'b1;
                    i_inst_class <= t.cls;
                    i_opcode <= t.op;
                    i_arg_first <= t.a1;
                    i_arg_second <= t.a2;
                    i_arg_third <= t.a3;
                end
            end else begin
                i_valid <= 1'b0;
                stim_done_r <= 1'b1;
            end
        end
    end

    int stall_left = 0;

    // Monitor: random receiver stalls, compare each result with the oldest one expected
    always @(posedge i_clk) begin
        t_outcome e;
        t_outcome got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_next_pc, o_flag_value, o_dest_value, o_dest_written, o_halted,
                        o_status};
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("ERROR: result with none expected: %p", got);
                end else begin
                    e = expected_results.pop_front();
                    if (got !== e) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("MISMATCH result %0d: expected %p got %p",
                                     results_seen, e, got);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= rand_gap();
            end
        end
    end

    // Run control: wait for the drain, then settle and report
    initial begin
        wait (stim_done_r && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Ran %0d instructions across memory, control and math classes,", sent);
        $display("with bad registers, unsupported ops, divide by zero and halt.");
        if (errors == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES) begin
            $display("Timeout with %0d results outstanding", expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/seu_pkg.sv
hdl/scalar_execute_unit.sv
verif/tb.sv
